// ----- hw/rtl/matrix_multiply_core_defines.svh -----
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mmc_pkg.sv -----
// Shared constants and types for the matrix multiply core.
package mmc_pkg;

   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 16;

   localparam int IDX_W   = 3;
   localparam int VALUE_W = 16;
   localparam int ACC_W   = 35;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS_B    = 2'd2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_FIELD_W = 2 * IDX_W + ACC_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // One multiply-accumulate step handed from the sequencer to the datapath.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             final_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mmc_issue_type;

endpackage

// ----- hw/rtl/mmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/mmc_seq.sv -----
// Shape registers and element/inner-index sequencer for the matrix multiply.
`include "matrix_multiply_core_defines.svh"

module mmc_seq #(
   parameter int MAX_DIM = 8,
   parameter int ADDR_W  = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mmc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mmc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           start,
   input  logic                           pipe_busy,
   input  logic                           out_valid,
   input  logic                           out_ready,
   output logic                           busy,
   output mmc_pkg::mmc_issue_type         issue,
   output logic [ADDR_W-1:0]              a_raddr,
   output logic [ADDR_W-1:0]              b_raddr
);

   import mmc_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WAIT  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             done_ff, done_in;
   logic             last_i, last_j, last_k;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v);
   endfunction

   assign last_i = (DIM_W'(i_ff) + DIM_W'(1)) == rows_ff;
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1)) == cols_ff;
   assign last_k = (DIM_W'(k_ff) + DIM_W'(1)) == inner_ff;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      issue.valid      = (state_ff == ST_ISSUE);
      issue.first      = (k_ff == '0);
      issue.last_k     = last_k;
      issue.final_elem = last_i && last_j;
      issue.row        = i_ff;
      issue.col        = j_ff;
   end

   assign a_raddr = ADDR_W'(32'(i_ff) * MAX_DIM + 32'(k_ff));
   assign b_raddr = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(j_ff));

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_ROWS_A:    rows_in  = clamp_dim(csr_wdata);
            CSR_INNER_DIM: inner_in = clamp_dim(csr_wdata);
            CSR_COLS_B:    cols_in  = clamp_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      done_in  = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WAIT;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               done_in  = 1'b0;
            end
         end
         ST_WAIT: begin
            // hold until the previous element has landed in the output register
            if (!pipe_busy) begin
               if (done_ff) begin
                  state_in = ST_IDLE;
               end else if (!out_valid || out_ready) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (last_k) begin
               k_in     = '0;
               state_in = ST_WAIT;
               if (last_j) begin
                  j_in = '0;
                  if (last_i) begin
                     done_in = 1'b1;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= DIM_W'(1);
         inner_ff <= DIM_W'(1);
         cols_ff  <= DIM_W'(1);
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         done_ff  <= done_in;
      end
   end

   `MMC_ASSERT_NOW(a_idle_pipe_empty, !busy, !pipe_busy, "datapath busy while idle")
   `MMC_ASSERT_NOW(a_slot_free, issue.valid && issue.first, !out_valid || out_ready,
                   "element started with output slot occupied")
   `MMC_ASSERT_NEXT(a_start_busy, start, busy, "compute transfer did not start sequencer")

endmodule

// ----- hw/rtl/mmc_mac.sv -----
// Multiply-accumulate datapath and result register for the matrix multiply.
`include "matrix_multiply_core_defines.svh"

module mmc_mac #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mmc_pkg::mmc_issue_type           issue,
   input  logic signed [DATA_WIDTH-1:0]     a_data,
   input  logic signed [DATA_WIDTH-1:0]     b_data,
   input  logic                             out_ready,
   output logic                             pipe_busy,
   output logic                             out_valid,
   output logic [mmc_pkg::IDX_W-1:0]        out_row,
   output logic [mmc_pkg::IDX_W-1:0]        out_col,
   output logic signed [mmc_pkg::ACC_W-1:0] out_value,
   output logic                             out_last
);

   import mmc_pkg::*;

   localparam int PROD_W = 2 * DATA_WIDTH;

   mmc_issue_type            s1_ff;
   mmc_issue_type            s2_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  sum;
   logic                     out_valid_ff;
   logic [IDX_W-1:0]         out_row_ff;
   logic [IDX_W-1:0]         out_col_ff;
   logic signed [ACC_W-1:0]  out_value_ff;
   logic                     out_last_ff;

   assign prod_in = a_data * b_data;

   // the sum is kept modulo 2^ACC_W, so wide products just drop their top bits
   generate
      if (PROD_W >= ACC_W) begin : g_trunc
         assign prod_ext = prod_ff[ACC_W-1:0];
      end else begin : g_sext
         assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   endgenerate

   assign sum = (s2_ff.first ? '0 : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         if (s2_ff.valid && s2_ff.last_k) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (s2_ff.valid) begin
         acc_ff <= sum;
      end
      if (s2_ff.valid && s2_ff.last_k) begin
         out_row_ff   <= s2_ff.row;
         out_col_ff   <= s2_ff.col;
         out_value_ff <= sum;
         out_last_ff  <= s2_ff.final_elem;
      end
   end

   assign pipe_busy = s1_ff.valid || s2_ff.valid;
   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_col   = out_col_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

   `MMC_ASSERT_NOW(a_no_overwrite, s2_ff.valid && s2_ff.last_k, !out_valid_ff || out_ready,
                   "result register overwritten before transfer")
   `MMC_ASSERT_NOW(a_result_source, $rose(out_valid_ff), $past(s2_ff.valid && s2_ff.last_k),
                   "result appeared without a finished sum")
   `MMC_ASSERT_NEXT(a_gap_after_elem, s1_ff.valid && s1_ff.last_k, !s1_ff.valid,
                    "next element issued before previous one drained")

endmodule

// ----- hw/rtl/matrix_multiply_core.sv -----
// Top level of the matrix multiply core: C = A x B in fixed point.
//
// Request channel (req_): each transfer carries one command in req_tuser.
//   Load A / load B write one Q8.8 element at (row, col) into the A or B
//   memory and produce no result; they are taken one per cycle while no
//   compute runs. Indexes at or beyond MAX_DIM are dropped, and so is the
//   unused command code. Compute emits rows_a * cols_b results on the
//   response channel (rsp_), row-major, each the exact Q19.16 dot product;
//   rsp_tlast marks the last. Each element reads one A and one B entry per
//   cycle through the single read port of each memory, then passes a
//   multiply stage and an accumulate stage; a new element starts only once
//   the previous one has left the datapath.
// req_tready is low while a compute runs; it rises once the last result is
//   in the output register, so a new item can enter while that one waits.
// A stalled rsp_tready holds the result register; the next element does not
//   start until its slot is free.
// Shape registers (csr_): 0 rows_a, 1 inner_dim, 2 cols_b; zero reads as 1
//   and values above MAX_DIM as MAX_DIM. Write them only while idle.
// Reset: shapes go to 1, the sequencer to idle; memory contents are kept
//   and must be loaded before use.
module matrix_multiply_core #(
   parameter int MAX_DIM    = mmc_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = mmc_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // row [2:0], col [5:3], value [21:6], zero [23:22]
   input  logic [mmc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [mmc_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_row [2:0], out_col [5:3], out_value [40:6], zero [47:41]
   output logic [mmc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [mmc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [mmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import mmc_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                   accept;
   logic [IDX_W-1:0]       in_row;
   logic [IDX_W-1:0]       in_col;
   logic [VALUE_W-1:0]     in_value;
   logic [DATA_WIDTH-1:0]  store_data;
   logic                   in_range;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   load_a;
   logic                   load_b;
   logic                   start;
   logic                   busy;
   logic                   pipe_busy;
   mmc_issue_type          issue;
   logic [ADDR_W-1:0]      a_raddr;
   logic [ADDR_W-1:0]      b_raddr;
   logic [DATA_WIDTH-1:0]  a_rdata;
   logic [DATA_WIDTH-1:0]  b_rdata;
   logic                   out_valid;
   logic [IDX_W-1:0]       out_row;
   logic [IDX_W-1:0]       out_col;
   logic signed [ACC_W-1:0] out_value;
   logic                   out_last;

   assign in_row   = req_tdata[IDX_W-1:0];
   assign in_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign in_value = req_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];

   // keep the low DATA_WIDTH bits of the value; a wider store zero-extends
   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_narrow
         assign store_data = in_value[DATA_WIDTH-1:0];
      end else begin : g_wide
         assign store_data = {{(DATA_WIDTH - VALUE_W){1'b0}}, in_value};
      end
   endgenerate

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
   assign wr_addr    = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
   assign load_a     = accept && (req_tuser == CMD_LOAD_A) && in_range;
   assign load_b     = accept && (req_tuser == CMD_LOAD_B) && in_range;
   assign start      = accept && (req_tuser == CMD_COMPUTE);

   mmc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (wr_addr),
      .wr_data (store_data),
      .rd_en   (issue.valid),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mmc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (wr_addr),
      .wr_data (store_data),
      .rd_en   (issue.valid),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   mmc_seq #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .start     (start),
      .pipe_busy (pipe_busy),
      .out_valid (out_valid),
      .out_ready (rsp_tready),
      .busy      (busy),
      .issue     (issue),
      .a_raddr   (a_raddr),
      .b_raddr   (b_raddr)
   );

   mmc_mac #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .a_data    (a_rdata),
      .b_data    (b_rdata),
      .out_ready (rsp_tready),
      .pipe_busy (pipe_busy),
      .out_valid (out_valid),
      .out_row   (out_row),
      .out_col   (out_col),
      .out_value (out_value),
      .out_last  (out_last)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_value, out_col, out_row};
   assign rsp_tlast  = out_last;

endmodule

// ----- bench/mmc_scoreboard_pkg.sv -----
// Scoreboard for the matrix multiply core: shadow memories, shape and expected C elements.
package mmc_scoreboard_pkg;
   import mmc_pkg::*;

   localparam int DIM = MAX_DIM_DEFAULT;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [ACC_W-1:0] value;
      logic             last;
   } c_elem_type;

   class mmc_scoreboard;
      logic [VALUE_W-1:0]    a_store [DIM*DIM];
      logic [VALUE_W-1:0]    b_store [DIM*DIM];
      logic [CSR_DATA_W-1:0] shape_reg [3];
      c_elem_type            c_expected [$];
      int                    mismatches;

      function new();
         foreach (a_store[i]) begin
            a_store[i] = '0;
            b_store[i] = '0;
         end
         foreach (shape_reg[i]) shape_reg[i] = 1;
         mismatches = 0;
      endfunction

      function void write_shape(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_ROWS_A:    shape_reg[0] = data;
            CSR_INNER_DIM: shape_reg[1] = data;
            CSR_COLS_B:    shape_reg[2] = data;
            default: ;
         endcase
      endfunction

      // Zero reads as one, anything above DIM as DIM.
      function int extent(int idx);
         int r;
         r = shape_reg[idx];
         if (r == 0) return 1;
         if (r > DIM) return DIM;
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value);
         int         n;
         int         p;
         int         m;
         longint     acc;
         c_elem_type e;
         case (cmd)
            CMD_LOAD_A: a_store[row*DIM+col] = value;
            CMD_LOAD_B: b_store[row*DIM+col] = value;
            CMD_COMPUTE: begin
               n = extent(CSR_ROWS_A);
               p = extent(CSR_INNER_DIM);
               m = extent(CSR_COLS_B);
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < m; j++) begin
                     acc = 0;
                     for (int k = 0; k < p; k++)
                        acc += longint'($signed(a_store[i*DIM+k])) *
                               longint'($signed(b_store[k*DIM+j]));
                     e.row   = IDX_W'(i);
                     e.col   = IDX_W'(j);
                     e.value = acc[ACC_W-1:0];
                     e.last  = (i == n-1) && (j == m-1);
                     c_expected.push_back(e);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                 logic [ACC_W-1:0] value, logic last);
         c_elem_type want;
         c_elem_type got;
         got.row   = row;
         got.col   = col;
         got.value = value;
         got.last  = last;
         if (c_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: row %0d col %0d value %0d last %0d",
                        got.row, got.col, $signed(got.value), got.last);
            return;
         end
         want = c_expected.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d/%0d %0d last %0d, got %0d/%0d %0d last %0d",
                        want.row, want.col, $signed(want.value), want.last,
                        got.row, got.col, $signed(got.value), got.last);
         end
      endfunction

      function int pending();
         return c_expected.size();
      endfunction

      function int failures();
         return mismatches + c_expected.size();
      endfunction
   endclass

endpackage

// ----- bench/tb_top.sv -----
// Top-level testbench for the matrix multiply core: stimulus, handshakes and final verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mmc_pkg::*;
   import mmc_scoreboard_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MEM_DIM       = MAX_DIM_DEFAULT;
   localparam int ITEM_TARGET   = 460;
   localparam int QUIET_ITEMS   = 60;
   localparam int SETTLE_CYCLES = 24;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   mmc_scoreboard sb;
   bit            a_loaded [MEM_DIM*MEM_DIM];
   bit            b_loaded [MEM_DIM*MEM_DIM];
   int            items_sent = 0;
   bit            quiet      = 1'b0;

   matrix_multiply_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return 4'd0;
         1:       return 4'd15;
         2:       return 4'd8;
         3:       return CSR_DATA_W'($urandom_range(9, 15));
         default: return CSR_DATA_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Hold valid until the transfer, then maybe open a gap before the next item.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
      @(negedge clock);
      req_tuser  = cmd;
      req_tdata  = {{(REQ_TDATA_W-2*IDX_W-VALUE_W){1'b0}}, value, col, row};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, row, col, value);
      if (cmd == CMD_LOAD_A) a_loaded[row*MEM_DIM+col] = 1'b1;
      if (cmd == CMD_LOAD_B) b_loaded[row*MEM_DIM+col] = 1'b1;
      if (cmd != CMD_UNUSED) items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
   endtask

   // Drain all expected results, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_shape(input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] inner,
                            input logic [CSR_DATA_W-1:0] cols);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = CSR_ROWS_A;
      csr_wdata = rows;
      @(negedge clock);
      csr_addr  = CSR_INNER_DIM;
      csr_wdata = inner;
      @(negedge clock);
      csr_addr  = CSR_COLS_B;
      csr_wdata = cols;
      @(negedge clock);
      csr_we    = 1'b0;
      sb.write_shape(CSR_ROWS_A, rows);
      sb.write_shape(CSR_INNER_DIM, inner);
      sb.write_shape(CSR_COLS_B, cols);
   endtask

   // Load every entry the current shape reads that was never written.
   task automatic fill_shape();
      int n;
      int p;
      int m;
      n = sb.extent(CSR_ROWS_A);
      p = sb.extent(CSR_INNER_DIM);
      m = sb.extent(CSR_COLS_B);
      for (int r = 0; r < n; r++)
         for (int k = 0; k < p; k++)
            if (!a_loaded[r*MEM_DIM+k])
               send_item(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), rand_value());
      for (int k = 0; k < p; k++)
         for (int c = 0; c < m; c++)
            if (!b_loaded[k*MEM_DIM+c])
               send_item(CMD_LOAD_B, IDX_W'(k), IDX_W'(c), rand_value());
   endtask

   task automatic run_compute();
      fill_shape();
      send_item(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
   endtask

   task automatic random_load();
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      int               sel;
      sel = $urandom_range(0, 15);
      cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
      if (sel == 0) cmd = CMD_UNUSED;
      if (sel <= 3) begin
         row = IDX_W'($urandom_range(0, MEM_DIM-1));
         col = IDX_W'($urandom_range(0, MEM_DIM-1));
      end else if (cmd == CMD_LOAD_A) begin
         row = IDX_W'($urandom_range(0, sb.extent(CSR_ROWS_A) - 1));
         col = IDX_W'($urandom_range(0, sb.extent(CSR_INNER_DIM) - 1));
      end else begin
         row = IDX_W'($urandom_range(0, sb.extent(CSR_INNER_DIM) - 1));
         col = IDX_W'($urandom_range(0, sb.extent(CSR_COLS_B) - 1));
      end
      send_item(cmd, row, col, rand_value());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[IDX_W-1:0], rsp_tdata[2*IDX_W-1:IDX_W],
                         rsp_tdata[2*IDX_W+ACC_W-1:2*IDX_W], rsp_tlast);
   end

   // Result side back-pressure in bursts; none once the run goes quiet.
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      #40_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Most negative operands, then a dropped unused command, then mixed signs.
      send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
      send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
      run_compute();
      send_item(CMD_UNUSED, 3'd7, 3'd7, 16'hFFFF);
      run_compute();
      send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
      run_compute();
      // Stored outside the current shape; read once the shape grows.
      send_item(CMD_LOAD_A, 3'd7, 3'd7, 16'hFFFF);
      send_item(CMD_LOAD_B, 3'd7, 3'd7, 16'h0001);
      wait_idle();
      set_shape(4'd0, 4'd0, 4'd0);
      run_compute();
      wait_idle();
      set_shape(4'd15, 4'd1, 4'd1);
      run_compute();

      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         set_shape(pick_dim(), pick_dim(), pick_dim());
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 10)) random_load();
            run_compute();
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
